### hw/rtl/bbsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbsf_pkg;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_PEEK  = 2'd1;
    localparam logic [1:0] ACT_POP   = 2'd2;
    localparam logic [1:0] ACT_END   = 2'd3;

    localparam logic [10:0] CAP_RESET = 11'd1024;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic [6:0] run_length;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        run_last;
        logic        accepted;
        logic [6:0]  popped_count;
        logic [10:0] fill_level;
        logic [10:0] room_left;
        logic [47:0] total_written;
        logic [47:0] total_read;
        logic        input_closed;
        logic        stream_done;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/bbsf_status.sv
`timescale 1ns / 1ps
`default_nettype none

module bbsf_status
    import bbsf_pkg::*;
#(
    parameter int WIDE = 11
)(
    input  wire logic [WIDE-1:0] cap_eff,
    input  wire logic [WIDE-1:0] fill,
    input  wire logic [47:0]     total_wr,
    input  wire logic [47:0]     total_rd,
    input  wire logic            closed,
    input  wire logic [7:0]      out_byte,
    input  wire logic            byte_valid,
    input  wire logic            run_last,
    input  wire logic            accepted,
    input  wire logic [6:0]      popped,
    output result_t              res
);

    logic [WIDE-1:0] room;

    // room saturates at zero when capacity was lowered below the fill
    assign room = (cap_eff > fill) ? (cap_eff - fill) : '0;

    always_comb
    begin
        res.out_byte      = out_byte;
        res.byte_valid    = byte_valid;
        res.run_last      = run_last;
        res.accepted      = accepted;
        res.popped_count  = popped;
        res.fill_level    = fill[10:0];
        res.room_left     = room[10:0];
        res.total_written = total_wr;
        res.total_read    = total_rd;
        res.input_closed  = closed;
        res.stream_done   = closed && (fill == '0);
    end

endmodule

`default_nettype wire

### hw/rtl/bounded_byte_stream_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded byte FIFO with peek. Commands are taken when start is high and busy
// is low; every result appears for one cycle with result_strobe and cannot be
// held off. Write, pop and end-input commands give one result the cycle after
// acceptance and may issue every cycle. A peek of n bytes reads the single-port
// byte memory one entry per cycle: each byte goes through rdata_reg, then the
// result register, and busy holds while peeking or while a byte is pending; an
// empty peek gives one result the next cycle with no busy time. Capacity is
// written through the cfg port while busy is low; values above DEPTH act as DEPTH.
module bounded_byte_stream_fifo
    import bbsf_pkg::*;
#(
    parameter int DEPTH   = 1024,
    parameter int MAX_RUN = 64
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire cmd_t        cmd,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data,
    output logic             result_strobe,
    output result_t          result
);

    localparam int AW   = $clog2(DEPTH);
    localparam int FW   = $clog2(DEPTH + 1);
    localparam int WIDE = (FW > 11) ? FW : 11;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PEEK = 1'b1;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    logic          state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [47:0]   wc_reg, wc_next;
    logic [47:0]   rc_reg, rc_next;
    logic          closed_reg, closed_next;
    logic [10:0]   cap_reg;
    logic          pend_reg, pend_next;
    logic          pend_last_reg, pend_last_next;
    logic          res_valid_reg, res_valid_next;
    result_t       res_reg, res_next;

    logic            go;
    logic            wr_en;
    logic            rd_en;
    logic [WIDE-1:0] cap_eff;
    logic [WIDE-1:0] fill_w;
    logic [6:0]      len_c;
    logic [6:0]      n_c;
    logic [AW:0]     head_sum;
    logic [7:0]      r_byte;
    logic            r_valid;
    logic            r_last;
    logic            r_acc;
    logic [6:0]      r_popped;

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    assign busy      = (state_reg == ST_PEEK) || pend_reg;
    assign cfg_ready = !busy;
    assign go        = start && !busy;

    assign cap_eff = (WIDE'(cap_reg) > WIDE'(DEPTH)) ? WIDE'(DEPTH) : WIDE'(cap_reg);
    assign fill_w  = WIDE'(fill_reg);
    assign len_c   = (cmd.run_length > 7'(MAX_RUN)) ? 7'(MAX_RUN) : cmd.run_length;
    assign n_c     = (WIDE'(len_c) < fill_w) ? len_c : 7'(fill_w);
    assign head_sum = {1'b0, head_reg} + (AW + 1)'(n_c);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        wc_next        = wc_reg;
        rc_next        = rc_reg;
        closed_next    = closed_reg;
        pend_next      = 1'b0;
        pend_last_next = 1'b0;
        res_valid_next = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        r_byte         = 8'd0;
        r_valid        = 1'b0;
        r_last         = 1'b1;
        r_acc          = 1'b0;
        r_popped       = 7'd0;

        // deliver the byte read last cycle
        if (pend_reg)
        begin
            res_valid_next = 1'b1;
            r_byte         = rdata_reg;
            r_valid        = 1'b1;
            r_last         = pend_last_reg;
        end

        if (state_reg == ST_PEEK)
        begin
            rd_en          = 1'b1;
            pend_next      = 1'b1;
            pend_last_next = (cnt_reg == 7'd1);
            ptr_next       = next_idx(ptr_reg);
            cnt_next       = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                state_next = ST_IDLE;
            end
        end

        if (go)
        begin
            unique case (cmd.action)
                ACT_WRITE:
                begin
                    res_valid_next = 1'b1;
                    if (fill_w < cap_eff)
                    begin
                        wr_en     = 1'b1;
                        r_acc     = 1'b1;
                        tail_next = next_idx(tail_reg);
                        fill_next = fill_reg + FW'(1);
                        wc_next   = wc_reg + 48'd1;
                    end
                end
                ACT_PEEK:
                begin
                    if (n_c == 7'd0)
                    begin
                        res_valid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_PEEK;
                        ptr_next   = head_reg;
                        cnt_next   = n_c;
                    end
                end
                ACT_POP:
                begin
                    res_valid_next = 1'b1;
                    r_popped       = n_c;
                    head_next      = (head_sum >= (AW + 1)'(DEPTH))
                                   ? AW'(head_sum - (AW + 1)'(DEPTH))
                                   : AW'(head_sum);
                    fill_next      = fill_reg - FW'(n_c);
                    rc_next        = rc_reg + 48'(n_c);
                end
                ACT_END:
                begin
                    res_valid_next = 1'b1;
                    closed_next    = 1'b1;
                end
            endcase
        end
    end

    bbsf_status #(
        .WIDE (WIDE)
    ) u_status (
        .cap_eff    (cap_eff),
        .fill       (WIDE'(fill_next)),
        .total_wr   (wc_next),
        .total_rd   (rc_next),
        .closed     (closed_next),
        .out_byte   (r_byte),
        .byte_valid (r_valid),
        .run_last   (r_last),
        .accepted   (r_acc),
        .popped     (r_popped),
        .res        (res_next)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= cmd.data_byte;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[ptr_reg];
        end
        res_reg <= res_next;
        ptr_reg <= ptr_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            wc_reg        <= '0;
            rc_reg        <= '0;
            closed_reg    <= 1'b0;
            cap_reg       <= CAP_RESET;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            wc_reg        <= wc_next;
            rc_reg        <= rc_next;
            closed_reg    <= closed_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    assign result_strobe = res_valid_reg;
    assign result        = res_reg;

endmodule

`default_nettype wire

### tb/sv/tb_bounded_byte_stream_fifo.sv
`timescale 1ns / 1ps

module tb_bounded_byte_stream_fifo;
    import bbsf_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int MAX_RUN   = 64;
    localparam int MAX_STEPS = 32;

    typedef struct {
        bit          is_cfg;
        logic [10:0] cap_value;
        cmd_t        cmd;
        bit          typed;
        result_t     reply;
    } step_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    cmd_t        cmd       = '0;
    logic        cfg_valid = 1'b0;
    logic [10:0] cfg_data  = '0;
    logic        busy;
    logic        cfg_ready;
    logic        result_strobe;
    result_t     result;

    // shadow copy of the stream state
    logic [7:0]  shadow_bytes [DEPTH];
    logic [9:0]  head_ptr;
    logic [9:0]  tail_ptr;
    logic [10:0] held;
    logic [10:0] cap_reg;
    logic [47:0] bytes_in;
    logic [47:0] bytes_out;
    logic        closed;

    // ring of awaited result words: the predictor adds, the checker takes
    result_t     awaited_replies [256];
    int unsigned await_put  = 0;
    int unsigned await_take = 0;
    step_row_t   steps [MAX_STEPS];
    int          step_total = 0;
    result_t     want_reply;
    int          mismatches = 0;

    bounded_byte_stream_fifo #(
        .DEPTH   (DEPTH),
        .MAX_RUN (MAX_RUN)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .result        (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t status(logic [7:0] ob, logic bv, logic last, logic acc,
                                       logic [6:0] popped, logic [10:0] fill,
                                       logic [10:0] room, logic [47:0] wr, logic [47:0] rd,
                                       logic cl, logic dn);
        result_t r;
        r.out_byte      = ob;
        r.byte_valid    = bv;
        r.run_last      = last;
        r.accepted      = acc;
        r.popped_count  = popped;
        r.fill_level    = fill;
        r.room_left     = room;
        r.total_written = wr;
        r.total_read    = rd;
        r.input_closed  = cl;
        r.stream_done   = dn;
        return r;
    endfunction

    function automatic int unsigned eff_capacity();
        return (cap_reg > DEPTH) ? DEPTH : cap_reg;
    endfunction

    function automatic result_t status_now(logic [7:0] ob, logic bv, logic last, logic acc,
                                           logic [6:0] popped);
        int unsigned eff;
        eff = eff_capacity();
        return status(ob, bv, last, acc, popped, held,
                      (eff > held) ? 11'(eff - held) : 11'd0,
                      bytes_in, bytes_out, closed, closed && (held == 0));
    endfunction

    function automatic void queue_reply(result_t r);
        awaited_replies[8'(await_put)] = r;
        await_put++;
    endfunction

    function automatic void predict_stream_cmd(cmd_t c);
        int unsigned len;
        int unsigned n;
        logic        ok;
        logic [9:0]  rd_ptr;
        len = (c.run_length > MAX_RUN) ? MAX_RUN : c.run_length;
        n   = (len < held) ? len : held;
        case (c.action)
            ACT_WRITE:
            begin
                ok = (held < eff_capacity());
                if (ok)
                begin
                    shadow_bytes[tail_ptr] = c.data_byte;
                    tail_ptr++;
                    held++;
                    bytes_in++;
                end
                queue_reply(status_now(8'd0, 1'b0, 1'b1, ok, 7'd0));
            end
            ACT_PEEK:
            begin
                if (n == 0)
                    queue_reply(status_now(8'd0, 1'b0, 1'b1, 1'b0, 7'd0));
                rd_ptr = head_ptr;
                for (int i = 0; i < n; i++)
                begin
                    queue_reply(status_now(shadow_bytes[rd_ptr], 1'b1,
                                           i == n - 1, 1'b0, 7'd0));
                    rd_ptr++;
                end
            end
            ACT_POP:
            begin
                head_ptr  = head_ptr + 10'(n);
                held      = held - 11'(n);
                bytes_out = bytes_out + 48'(n);
                queue_reply(status_now(8'd0, 1'b0, 1'b1, 1'b0, 7'(n)));
            end
            default:
            begin
                closed = 1'b1;
                queue_reply(status_now(8'd0, 1'b0, 1'b1, 1'b0, 7'd0));
            end
        endcase
    endfunction

    function automatic cmd_t make_cmd(logic [1:0] act, logic [7:0] data, logic [6:0] len);
        cmd_t c;
        c.action     = act;
        c.data_byte  = data;
        c.run_length = len;
        return c;
    endfunction

    function automatic void add_row(logic [1:0] act, logic [7:0] data, logic [6:0] len,
                                    bit typed, result_t reply);
        step_row_t row;
        row.is_cfg    = 1'b0;
        row.cap_value = '0;
        row.cmd       = make_cmd(act, data, len);
        row.typed     = typed;
        row.reply     = reply;
        steps[step_total] = row;
        step_total++;
    endfunction

    function automatic void add_cfg(logic [10:0] value);
        step_row_t row;
        row.is_cfg    = 1'b1;
        row.cap_value = value;
        row.cmd       = '0;
        row.typed     = 1'b0;
        row.reply     = '0;
        steps[step_total] = row;
        step_total++;
    endfunction

    function automatic logic [6:0] random_run();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 7'd0;
        if (r < 70)
            return 7'($urandom_range(1, 16));
        if (r < 90)
            return 7'($urandom_range(17, 64));
        return 7'($urandom_range(65, 127));
    endfunction

    function automatic cmd_t random_cmd(int write_pct);
        int unsigned r;
        logic [1:0]  act;
        r = $urandom_range(0, 99);
        if (r < write_pct)
            act = ACT_WRITE;
        else if (r >= 98)
            act = ACT_END;
        else if (r[0])
            act = ACT_PEEK;
        else
            act = ACT_POP;
        return make_cmd(act, 8'($urandom_range(0, 255)), random_run());
    endfunction

    function automatic int pick_gap(bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // hold start until the block takes the word, then predict its results
    task automatic send_cmd(cmd_t c, bit typed, result_t typed_reply);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_stream_cmd(c);
        if (typed)
            awaited_replies[8'(await_put - 1)] = typed_reply;
    endtask

    task automatic pause_sender(int gap, bit drain);
        if (gap > 0 || drain)
            start <= 1'b0;
        repeat (gap)
            @(posedge clk);
        if (drain)
            while (await_put != await_take || busy)
                @(posedge clk);
    endtask

    task automatic write_capacity(logic [10:0] value);
        pause_sender(0, 1'b1);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cap_reg = value;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_strobe === 1'b1)
        begin
            if (await_put == await_take)
            begin
                $error("result word with nothing awaited");
                mismatches++;
            end
            else
            begin
                want_reply = awaited_replies[8'(await_take)];
                await_take++;
                check_field("out_byte", want_reply.out_byte, result.out_byte);
                check_field("byte_valid", want_reply.byte_valid, result.byte_valid);
                check_field("run_last", want_reply.run_last, result.run_last);
                check_field("accepted", want_reply.accepted, result.accepted);
                check_field("popped_count", want_reply.popped_count, result.popped_count);
                check_field("fill_level", want_reply.fill_level, result.fill_level);
                check_field("room_left", want_reply.room_left, result.room_left);
                check_field("total_written", want_reply.total_written, result.total_written);
                check_field("total_read", want_reply.total_read, result.total_read);
                check_field("input_closed", want_reply.input_closed, result.input_closed);
                check_field("stream_done", want_reply.stream_done, result.stream_done);
            end
        end
    end

    initial
    begin
        #8ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        step_row_t   row;
        int unsigned phase_caps [8];
        bit          steady;

        head_ptr  = '0;
        tail_ptr  = '0;
        held      = '0;
        bytes_in  = '0;
        bytes_out = '0;
        closed    = 1'b0;
        cap_reg   = CAP_RESET;

        // empty stream after reset, then extremes of length and data
        add_row(ACT_PEEK, 8'hC3, 7'd0, 1, status(0, 0, 1, 0, 0, 0, 1024, 0, 0, 0, 0));
        add_row(ACT_POP, 8'h00, 7'd127, 1, status(0, 0, 1, 0, 0, 0, 1024, 0, 0, 0, 0));
        add_row(ACT_WRITE, 8'h00, 7'd0, 1, status(0, 0, 1, 1, 0, 1, 1023, 1, 0, 0, 0));
        add_row(ACT_WRITE, 8'hFF, 7'd127, 1, status(0, 0, 1, 1, 0, 2, 1022, 2, 0, 0, 0));
        add_row(ACT_WRITE, 8'hA5, 7'd64, 1, status(0, 0, 1, 1, 0, 3, 1021, 3, 0, 0, 0));
        add_row(ACT_PEEK, 8'h5A, 7'd2, 0, '0);
        add_row(ACT_PEEK, 8'h00, 7'd127, 0, '0);
        add_row(ACT_POP, 8'hFF, 7'd1, 1, status(0, 0, 1, 0, 1, 2, 1022, 3, 1, 0, 0));
        // capacity below the fill: writes are refused while pops drain the stream
        add_cfg(11'd1);
        add_row(ACT_WRITE, 8'h5A, 7'd0, 1, status(0, 0, 1, 0, 0, 2, 0, 3, 1, 0, 0));
        add_row(ACT_POP, 8'h00, 7'd1, 1, status(0, 0, 1, 0, 1, 1, 0, 3, 2, 0, 0));
        add_row(ACT_WRITE, 8'h3C, 7'd0, 1, status(0, 0, 1, 0, 0, 1, 0, 3, 2, 0, 0));
        add_row(ACT_POP, 8'h00, 7'd64, 1, status(0, 0, 1, 0, 1, 0, 1, 3, 3, 0, 0));
        add_cfg(11'd0);
        add_row(ACT_WRITE, 8'h11, 7'd0, 1, status(0, 0, 1, 0, 0, 0, 0, 3, 3, 0, 0));
        add_row(ACT_PEEK, 8'h00, 7'd5, 1, status(0, 0, 1, 0, 0, 0, 0, 3, 3, 0, 0));
        add_cfg(11'h7FF);
        add_row(ACT_WRITE, 8'h80, 7'd0, 1, status(0, 0, 1, 1, 0, 1, 1023, 4, 3, 0, 0));
        add_row(ACT_END, 8'h00, 7'd0, 1, status(0, 0, 1, 0, 0, 1, 1023, 4, 3, 1, 0));
        add_row(ACT_WRITE, 8'h7F, 7'd0, 1, status(0, 0, 1, 1, 0, 2, 1022, 5, 3, 1, 0));
        add_row(ACT_PEEK, 8'h00, 7'd64, 0, '0);
        add_row(ACT_POP, 8'h00, 7'd64, 1, status(0, 0, 1, 0, 2, 0, 1024, 5, 5, 1, 1));
        add_row(ACT_END, 8'hFF, 7'd127, 1, status(0, 0, 1, 0, 0, 0, 1024, 5, 5, 1, 1));
        add_row(ACT_WRITE, 8'h01, 7'd0, 0, '0);
        add_row(ACT_PEEK, 8'h00, 7'd0, 0, '0);
        add_row(ACT_PEEK, 8'h00, 7'd1, 0, '0);

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < step_total; i++)
        begin
            row = steps[i];
            if (row.is_cfg)
                write_capacity(row.cap_value);
            else
            begin
                send_cmd(row.cmd, row.typed, row.reply);
                pause_sender(pick_gap(1'b0), 1'b0);
            end
        end

        phase_caps = '{$urandom_range(1, 8), 0, 1024, $urandom_range(9, 100), 1, 2047,
                       $urandom_range(1, 2047), 1024};
        foreach (phase_caps[p])
        begin
            write_capacity(11'(phase_caps[p]));
            steady = ($urandom_range(0, 2) == 0);
            repeat (56)
            begin
                send_cmd(random_cmd((phase_caps[p] <= 8) ? 70 : 50), 1'b0, '0);
                pause_sender(pick_gap(steady), $urandom_range(0, 39) == 0);
            end
        end

        pause_sender(0, 1'b1);
        repeat (MAX_RUN + 4)
            @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
